FILE: sv/hedc_pkg.sv
package hedc_pkg;

    localparam int CODE_BITS = 63;
    localparam int DATA_BITS = 57;
    localparam int SYN_BITS  = 6;
    localparam int PC_BITS   = 3;

    typedef enum logic [1:0] {
        FUNC_ENCODE = 2'd0,
        FUNC_DECODE = 2'd1,
        FUNC_CHECK  = 2'd2
    } t_func;

    localparam logic [SYN_BITS-1:0] CODE_LENGTH_RESET = 6'd7;

    typedef struct packed {
        logic [1:0]           func;
        logic [DATA_BITS-1:0] data_word;
        logic [CODE_BITS-1:0] code_word;
    } t_ham_in;

    typedef struct packed {
        logic [CODE_BITS-1:0] code_out;
        logic [DATA_BITS-1:0] data_out;
        logic [SYN_BITS-1:0]  syndrome;
        logic                 corrected;
        logic                 word_valid;
        logic [PC_BITS-1:0]   parity_count;
    } t_ham_out;

    function automatic logic is_pow2(input int q);
        return (q & (q - 1)) == 0;
    endfunction

    // XOR of the positions of the set bits (bit i is position i+1)
    function automatic logic [SYN_BITS-1:0] syn_of(input logic [CODE_BITS-1:0] w);
        logic [SYN_BITS-1:0] s;
        s = '0;
        for (int q = 1; q <= CODE_BITS; q++) begin
            if (w[q-1]) begin
                s = s ^ SYN_BITS'(q);
            end
        end
        return s;
    endfunction

endpackage

FILE: sv/hamming_encode_decode_check.sv
// Hamming single-error-correcting codec, code length set by one register.
// Input channel: i_valid / o_ready carry a t_ham_in (func, data_word,
// code_word). Output channel: o_valid / i_ready carry a t_ham_out.
// func encode builds a code word, decode corrects a single bit error and
// extracts the data bits, check reports the syndrome and word_valid.
// Configuration: i_cfg_we writes i_cfg_wdata into code_length at once;
// write it only while no word is in flight.
// Path: the input register, then XOR trees into the result register, which
// raises o_valid once it loads the word. Throughput: one word per cycle
// while i_ready stays high.
// When the receiver holds i_ready low the result register holds its word,
// the input register fills behind it, and o_ready drops once both are full.
// Reset (i_rst_n low, synchronous): both stages empty, code_length
// returns to 7.
module hamming_encode_decode_check
    import hedc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_ham_in             i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output t_ham_out            o_data,
    input  logic                i_cfg_we,
    input  logic [SYN_BITS-1:0] i_cfg_wdata
);

    logic [SYN_BITS-1:0]  r_code_length;
    logic                 r_s1_valid;
    t_ham_in              r_s1_data;
    logic                 r_out_valid;
    t_ham_out             r_out;
    t_ham_out             n_out;

    logic                 out_load;
    logic                 s1_load;

    logic [CODE_BITS-1:0] mask;
    logic [CODE_BITS-1:0] enc_data;
    logic [SYN_BITS-1:0]  enc_syn;
    logic [CODE_BITS-1:0] enc_word;
    logic [CODE_BITS-1:0] dec_in;
    logic [SYN_BITS-1:0]  dec_syn;
    logic                 dec_flip;
    logic [CODE_BITS-1:0] dec_word;
    logic [DATA_BITS-1:0] dec_data;
    logic [PC_BITS-1:0]   pc;

    assign out_load = r_s1_valid && (!r_out_valid || i_ready);
    assign s1_load  = i_valid && o_ready;
    assign o_ready  = !r_s1_valid || out_load;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    // position masks and parity counts follow code_length; data placement is fixed wiring
    always_comb begin
        int k;
        mask     = '0;
        enc_data = '0;
        dec_data = '0;
        pc       = '0;
        for (int q = 1; q <= CODE_BITS; q++) begin
            mask[q-1] = (q <= int'(r_code_length));
        end
        for (int j = 0; j < SYN_BITS; j++) begin
            if ((1 << j) <= int'(r_code_length)) begin
                pc = pc + PC_BITS'(1);
            end
        end

        // encode: data bits into non-power-of-two positions, then parity
        k = 0;
        for (int q = 1; q <= CODE_BITS; q++) begin
            if (!is_pow2(q)) begin
                enc_data[q-1] = r_s1_data.data_word[k] & mask[q-1];
                k = k + 1;
            end
        end
        enc_syn  = syn_of(enc_data);
        enc_word = enc_data;
        for (int j = 0; j < SYN_BITS; j++) begin
            if (enc_syn[j]) begin
                enc_word[(1 << j) - 1] = 1'b1;
            end
        end
        enc_word = enc_word & mask;

        // decode: syndrome over the in-length bits, flip, extract
        dec_in   = r_s1_data.code_word & mask;
        dec_syn  = syn_of(dec_in);
        dec_flip = (dec_syn != '0) && (dec_syn <= r_code_length);
        dec_word = dec_in;
        if (dec_flip) begin
            dec_word = dec_in ^ (CODE_BITS'(1) << (dec_syn - SYN_BITS'(1)));
        end
        k = 0;
        for (int q = 1; q <= CODE_BITS; q++) begin
            if (!is_pow2(q)) begin
                dec_data[k] = dec_word[q-1];
                k = k + 1;
            end
        end
    end

    always_comb begin
        n_out              = '0;
        n_out.parity_count = pc;
        unique case (r_s1_data.func)
            FUNC_ENCODE: begin
                n_out.code_out = enc_word;
            end
            FUNC_DECODE: begin
                n_out.data_out   = dec_data;
                n_out.syndrome   = dec_syn;
                n_out.corrected  = dec_flip;
                n_out.word_valid = (dec_syn == '0);
            end
            FUNC_CHECK: begin
                n_out.syndrome   = dec_syn;
                n_out.word_valid = (dec_syn == '0);
            end
            default: begin
                n_out.code_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_length <= CODE_LENGTH_RESET;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_code_length <= i_cfg_wdata;
            end
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_data <= i_data;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    // a result appears only when the input stage held a word
    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("result register filled without an input word");

    // hold a word in the input stage until it moves on
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_load |=> r_s1_valid && $stable(r_s1_data))
        else $error("input stage lost or changed a waiting word");

    // a correction means a nonzero syndrome
    a_corr_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.corrected |-> !o_data.word_valid && o_data.syndrome != '0)
        else $error("corrected set with a zero syndrome");

    // encode and decode results never mix
    a_enc_dec_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.code_out != '0 |-> o_data.data_out == '0 && o_data.syndrome == '0)
        else $error("encode result carries decode fields");

endmodule

FILE: tb/sv/hamming_codec_checker.sv
`timescale 1ns / 100ps

module hamming_codec_checker
    import hedc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  t_ham_in             i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  t_ham_out            i_out_data,
    input  logic                i_cfg_we,
    input  logic [SYN_BITS-1:0] i_cfg_wdata,
    output int                  o_pending,
    output int                  o_fail_count
);

    t_ham_out            predicted_words[$];
    logic [SYN_BITS-1:0] cfg_len = CODE_LENGTH_RESET;
    int                  fails = 0;

    function automatic logic is_parity_pos(input int q);
        return (q & (q - 1)) == 0;
    endfunction

    // XOR of the positions 1..n whose bits are set
    function automatic logic [SYN_BITS-1:0] position_xor(input logic [CODE_BITS-1:0] w,
                                                         input int n);
        logic [SYN_BITS-1:0] acc;
        acc = '0;
        for (int q = 1; q <= n; q++) begin
            if (w[q-1]) begin
                acc = acc ^ SYN_BITS'(q);
            end
        end
        return acc;
    endfunction

    function automatic t_ham_out codec_result(input t_ham_in w, input logic [SYN_BITS-1:0] len);
        t_ham_out            r;
        logic [CODE_BITS-1:0] word;
        logic [SYN_BITS-1:0]  s;
        int                   n;
        int                   k;
        r    = '0;
        word = '0;
        n    = int'(len);
        k    = 0;
        for (int q = 1; q <= n; q++) begin
            if (is_parity_pos(q)) begin
                r.parity_count = r.parity_count + 1'b1;
            end
        end
        case (w.func)
            FUNC_ENCODE: begin
                for (int q = 1; q <= n; q++) begin
                    if (!is_parity_pos(q)) begin
                        if (k < DATA_BITS && w.data_word[k]) begin
                            word[q-1] = 1'b1;
                        end
                        k++;
                    end
                end
                // parity bits take the syndrome of the data bits alone
                s = position_xor(word, n);
                for (int p = 1; p <= n; p = p * 2) begin
                    if ((s & p) != 0) begin
                        word[p-1] = 1'b1;
                    end
                end
                r.code_out = word;
            end
            FUNC_DECODE, FUNC_CHECK: begin
                for (int q = 1; q <= n; q++) begin
                    word[q-1] = w.code_word[q-1];
                end
                s            = position_xor(word, n);
                r.syndrome   = s;
                r.word_valid = (s == 0);
                if (w.func == FUNC_DECODE) begin
                    // a syndrome past the length flips nothing
                    if (s >= 1 && s <= n) begin
                        word[s-1]   = ~word[s-1];
                        r.corrected = 1'b1;
                    end
                    for (int q = 1; q <= n; q++) begin
                        if (!is_parity_pos(q)) begin
                            if (k < DATA_BITS && word[q-1]) begin
                                r.data_out[k] = 1'b1;
                            end
                            k++;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", field, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_ham_out want;
        if (!i_rst_n) begin
            predicted_words.delete();
            cfg_len = CODE_LENGTH_RESET;
        end else begin
            if (i_cfg_we) begin
                cfg_len = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) begin
                predicted_words.insert(predicted_words.size(),
                                       codec_result(i_in_data, cfg_len));
            end
            if (i_out_valid && i_out_ready) begin
                if (predicted_words.size() == 0) begin
                    $error("result transfer with nothing outstanding: %h", i_out_data);
                    fails++;
                end else begin
                    want = predicted_words.pop_front();
                    check_field("code_out", 64'(want.code_out),
                                64'(i_out_data.code_out));
                    check_field("data_out", 64'(want.data_out),
                                64'(i_out_data.data_out));
                    check_field("syndrome", 64'(want.syndrome),
                                64'(i_out_data.syndrome));
                    check_field("corrected", 64'(want.corrected),
                                64'(i_out_data.corrected));
                    check_field("word_valid", 64'(want.word_valid),
                                64'(i_out_data.word_valid));
                    check_field("parity_count", 64'(want.parity_count),
                                64'(i_out_data.parity_count));
                end
            end
        end
        o_pending    <= predicted_words.size();
        o_fail_count <= fails;
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import hedc_pkg::*;

    localparam logic [1:0] FUNC_UNUSED     = 2'd3;
    localparam int         NUM_PHASES      = 17;
    localparam int         ITEMS_PER_PHASE = 76;
    localparam int         DIRECTED_PHASES = 4;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    t_ham_in             i_data;
    logic                o_valid;
    logic                i_ready;
    t_ham_out            o_data;
    logic                i_cfg_we;
    logic [SYN_BITS-1:0] i_cfg_wdata;

    int   pending;
    int   fail_count;
    logic calm;
    int   cur_len;
    int   phase_len[NUM_PHASES] = '{7, 12, 63, 2, 3, 0, 1, 4, 5, 15, 16, 31, 32, 40, 58, 62, 63};

    hamming_encode_decode_check DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    hamming_codec_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [CODE_BITS-1:0] random_code();
        return CODE_BITS'({$urandom, $urandom});
    endfunction

    // Mostly clean words with zero or one flipped bit; some double flips and noise
    function automatic t_ham_in make_item(input int n);
        t_ham_in              it;
        logic [CODE_BITS-1:0] mask;
        logic [CODE_BITS-1:0] w;
        logic [SYN_BITS-1:0]  s;
        int                   pick;
        pick = $urandom_range(0, 19);
        if (pick < 7) begin
            it.func = FUNC_ENCODE;
        end else if (pick < 14) begin
            it.func = FUNC_DECODE;
        end else if (pick < 18) begin
            it.func = FUNC_CHECK;
        end else begin
            it.func = FUNC_UNUSED;
        end
        it.data_word = DATA_BITS'({$urandom, $urandom});
        mask = {CODE_BITS{1'b1}} >> (CODE_BITS - n);
        w    = random_code() & mask;
        s    = '0;
        for (int q = 1; q <= n; q++) begin
            if (w[q-1]) begin
                s = s ^ SYN_BITS'(q);
            end
        end
        for (int p = 1; p <= n; p = p * 2) begin
            if ((s & p) != 0) begin
                w[p-1] = ~w[p-1];
            end
        end
        pick = $urandom_range(0, 9);
        if (n > 0) begin
            if (pick >= 4 && pick <= 8) begin
                w[$urandom_range(1, n) - 1] ^= 1'b1;
            end
            if (pick == 8) begin
                w[$urandom_range(1, n) - 1] ^= 1'b1;
            end
        end
        if (pick == 9) begin
            w = random_code() & mask;
        end
        if ($urandom_range(0, 1) == 1) begin
            w = w | (random_code() & ~mask);
        end
        it.code_word = w;
        return it;
    endfunction

    // Leaves valid high after the transfer so back-to-back items need no toggle
    task automatic send_item(input t_ham_in it);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_code_length(input int len);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= SYN_BITS'(len);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_directed(input int n);
        t_ham_in              it;
        logic [CODE_BITS-1:0] beyond;
        int                   p;
        p = 1;
        while (p * 2 <= n) p = p * 2;
        // two top positions whose XOR lands past the length when n < 2p-1
        beyond      = '0;
        beyond[p-1] = 1'b1;
        if (p > 1) beyond[p-2] = 1'b1;

        it = '{func: FUNC_ENCODE, data_word: '1, code_word: '0};
        send_item(it);
        it = '{func: FUNC_ENCODE, data_word: '0, code_word: '1};
        send_item(it);
        it = '{func: FUNC_DECODE, data_word: '0, code_word: '1};
        send_item(it);
        it = '{func: FUNC_CHECK, data_word: '1, code_word: '0};
        send_item(it);
        it = '{func: FUNC_UNUSED, data_word: '1, code_word: '1};
        send_item(it);
        it = '{func: FUNC_DECODE, data_word: '0, code_word: beyond};
        send_item(it);
    endtask

    // Receiver: random stall bursts until the calm stretch
    initial begin
        i_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    initial begin
        calm        = 1'b0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        phase_len[13] = $urandom_range(3, 63);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // the first phase runs at the reset length
            if (ph > 0) begin
                i_valid <= 1'b0;
                write_code_length(phase_len[ph]);
            end
            cur_len = phase_len[ph];
            if (ph == NUM_PHASES - 1) calm = 1'b1;
            if (ph < DIRECTED_PHASES) run_directed(cur_len);
            repeat (ITEMS_PER_PHASE) send_item(make_item(cur_len));
        end
        i_valid <= 1'b0;

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/hedc_pkg.sv
sv/hamming_encode_decode_check.sv
tb/sv/hamming_codec_checker.sv
tb/sv/tb_top.sv
